>>> rtl/core/odm_pkg.sv
// ============================================================================
// odm_pkg - shared types and constants for the ordered dither block
// Sizes of the threshold store, the position counters, register codes,
// command codes and the fixed output levels.
// ============================================================================
package odm_pkg;

    localparam int MAX_TILE_SIDE   = 32;
    localparam int ENTRY_BITS      = 16;
    localparam int MAX_IMAGE_WIDTH = 4096;

    localparam int TILE_IDX_W  = $clog2(MAX_TILE_SIDE);
    localparam int TILE_SIDE_W = TILE_IDX_W + 1;
    localparam int STORE_DEPTH = MAX_TILE_SIDE * MAX_TILE_SIDE;
    localparam int ADDR_W      = 2 * TILE_IDX_W;
    localparam int COL_W       = $clog2(MAX_IMAGE_WIDTH);

    // Field widths of the channels.
    localparam int IMG_W_W    = 13;
    localparam int TILE_CFG_W = 6;
    localparam int DIV_W      = 19;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    // Threshold entries are scaled by 255 * 256 before the compare.
    localparam int          PROD_W      = 32;
    localparam logic [15:0] ENTRY_SCALE = 16'd65280;
    localparam logic [7:0]  PIX_FULL    = 8'd255;

    localparam logic [7:0] OUT_BLACK = 8'd0;
    localparam logic [7:0] OUT_WHITE = 8'd255;
    localparam logic [7:0] OUT_CLEAR = 8'd128;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_TILE_WIDTH  = 2'd1,
        CFG_TILE_HEIGHT = 2'd2,
        CFG_DIVISOR_Q8  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [IMG_W_W-1:0]    image_width;
        logic [TILE_CFG_W-1:0] tile_width;
        logic [TILE_CFG_W-1:0] tile_height;
        logic [DIV_W-1:0]      divisor_q8;
    } t_cfg;

    // Effective tile side: zero acts as one, oversize acts as the maximum.
    function automatic logic [TILE_SIDE_W-1:0] clamp_side(input logic [TILE_CFG_W-1:0] v);
        logic [TILE_SIDE_W-1:0] r;
        if (v == '0) begin
            r = TILE_SIDE_W'(1);
        end else if (32'(v) > MAX_TILE_SIDE) begin
            r = TILE_SIDE_W'(MAX_TILE_SIDE);
        end else begin
            r = TILE_SIDE_W'(v);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/odm_ifs.sv
// ============================================================================
// odm_ifs - channel interfaces of the ordered dither block
// Pixel and load items in, dithered results out, and register writes.
// ============================================================================
interface odm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [odm_pkg::ADDR_W-1:0]  entry_index;
    logic [15:0]                 entry_value;
    logic [odm_pkg::PIX_W-1:0]   pixel_value;
    logic                        opaque;
    logic                        frame_start;

    modport source (output valid, cmd, entry_index, entry_value, pixel_value, opaque,
                    frame_start, input ready);
    modport sink   (input valid, cmd, entry_index, entry_value, pixel_value, opaque,
                    frame_start, output ready);
endinterface

interface odm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_value;

    modport source (output valid, out_value, input ready);
    modport sink   (input valid, out_value, output ready);
endinterface

interface odm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [odm_pkg::CFG_IDX_W-1:0]     index;
    logic [odm_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/odm_thresh_ram.sv
// ============================================================================
// odm_thresh_ram - threshold matrix store
// One write port and one read port with registered read data.
// ============================================================================
module odm_thresh_ram (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [odm_pkg::ADDR_W-1:0]     i_wr_addr,
    input  logic [odm_pkg::ENTRY_BITS-1:0] i_wr_data,
    input  logic                           i_rd_en,
    input  logic [odm_pkg::ADDR_W-1:0]     i_rd_addr,
    output logic [odm_pkg::ENTRY_BITS-1:0] o_rd_data
);
    import odm_pkg::*;

    logic [ENTRY_BITS-1:0] r_mem [STORE_DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/odm_position.sv
// ============================================================================
// odm_position - raster position and tile phase tracker
// Gives the threshold address of the current pixel and steps the image
// column and the tile row and column after each pixel.
// ============================================================================
module odm_position (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  odm_pkg::t_cfg              i_cfg,
    input  logic                       i_step,
    input  logic                       i_frame_start,
    output logic [odm_pkg::ADDR_W-1:0] o_addr
);
    import odm_pkg::*;

    logic [COL_W-1:0]       r_col, n_col;
    logic [TILE_IDX_W-1:0]  r_tcol, n_tcol;
    logic [TILE_IDX_W-1:0]  r_trow, n_trow;

    logic [COL_W-1:0]       col_base;
    logic [TILE_IDX_W-1:0]  tcol_base, trow_base;
    logic [COL_W:0]         col_next;
    logic [TILE_SIDE_W-1:0] tcol_next, trow_next;
    logic [TILE_SIDE_W-1:0] tw, th;
    logic                   row_end;

    always_comb begin
        // A frame start clears the position before the pixel uses it.
        col_base  = i_frame_start ? '0 : r_col;
        tcol_base = i_frame_start ? '0 : r_tcol;
        trow_base = i_frame_start ? '0 : r_trow;

        tw        = clamp_side(i_cfg.tile_width);
        th        = clamp_side(i_cfg.tile_height);
        col_next  = {1'b0, col_base} + (COL_W+1)'(1);
        tcol_next = {1'b0, tcol_base} + TILE_SIDE_W'(1);
        trow_next = {1'b0, trow_base} + TILE_SIDE_W'(1);
        row_end   = (32'(col_next) >= 32'(i_cfg.image_width))
                 || (32'(col_next) >= MAX_IMAGE_WIDTH);

        if (row_end) begin
            n_col  = '0;
            n_tcol = '0;
            n_trow = (trow_next >= th) ? '0 : trow_next[TILE_IDX_W-1:0];
        end else begin
            n_col  = col_next[COL_W-1:0];
            n_tcol = (tcol_next >= tw) ? '0 : tcol_next[TILE_IDX_W-1:0];
            n_trow = trow_base;
        end
    end

    assign o_addr = {trow_base, tcol_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_tcol <= '0;
            r_trow <= '0;
        end else if (i_step) begin
            r_col  <= n_col;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
        end
    end

endmodule

>>> rtl/core/ordered_dither_mono.sv
// ============================================================================
// ordered_dither_mono - monochrome ordered dithering of a pixel stream
// Threshold matrix loads and raster pixels in, one dithered level per pixel.
// ============================================================================
// The block takes one item per clock when the output side keeps up. A load
// item (cmd 0) writes one threshold entry at row*32+column and gives no
// result. A pixel item (cmd 1) gives exactly one result once it is
// accepted: its threshold entry is first read from the block RAM, whose read
// data is registered, and the compare stage then fills the output
// register. An opaque pixel comes out as 255 when
// pixel*D + entry*65280 > 255*D, with D the Q.8 divisor, and as 0
// otherwise; a transparent pixel comes out as 128. The frame_start mark on
// a pixel clears the column count and the tile phases before that pixel is
// used. Throughput is one item per cycle; ready drops only while both the
// compare stage and the output register hold items the sink has not taken.
// Threshold entries read back before they are written hold unknown data.
// Registers may be written only while no pixel is in flight.
module ordered_dither_mono (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odm_in_if.sink    i_pix,
    odm_cfg_if.sink   i_cfg,
    odm_out_if.source o_res
);
    import odm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= IMG_W_W'(1);
            r_cfg.tile_width  <= TILE_CFG_W'(4);
            r_cfg.tile_height <= TILE_CFG_W'(4);
            r_cfg.divisor_q8  <= DIV_W'(4096);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_IMAGE_WIDTH: r_cfg.image_width <= i_cfg.data[IMG_W_W-1:0];
                CFG_TILE_WIDTH:  r_cfg.tile_width  <= i_cfg.data[TILE_CFG_W-1:0];
                CFG_TILE_HEIGHT: r_cfg.tile_height <= i_cfg.data[TILE_CFG_W-1:0];
                CFG_DIVISOR_Q8:  r_cfg.divisor_q8  <= i_cfg.data[DIV_W-1:0];
                default:         r_cfg.image_width <= r_cfg.image_width;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Stage one holds the threshold read, the
    // output register holds the finished level.
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_adv;
    logic s1_adv;
    logic in_acc;
    logic is_pixel;
    logic is_load;

    assign out_adv     = !r_out_valid || o_res.ready;
    assign s1_adv      = !r_s1_valid || out_adv;
    assign i_pix.ready = s1_adv;
    assign in_acc      = i_pix.valid && s1_adv;
    assign is_pixel    = in_acc && (t_cmd'(i_pix.cmd) == CMD_PIXEL);
    assign is_load     = in_acc && (t_cmd'(i_pix.cmd) == CMD_LOAD);

    // ------------------------------------------------------------------
    // Position tracking and threshold store.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_BITS-1:0] rd_entry;

    odm_position u_position (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_step        (is_pixel),
        .i_frame_start (i_pix.frame_start),
        .o_addr        (rd_addr)
    );

    odm_thresh_ram u_thresh_ram (
        .i_clk     (i_clk),
        .i_wr_en   (is_load),
        .i_wr_addr (i_pix.entry_index),
        .i_wr_data (i_pix.entry_value[ENTRY_BITS-1:0]),
        .i_rd_en   (is_pixel),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_entry)
    );

    // ------------------------------------------------------------------
    // Stage one: pixel attributes travel alongside the RAM read.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s1_pixel;
    logic             r_s1_opaque;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= is_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_pixel) begin
            r_s1_pixel  <= i_pix.pixel_value;
            r_s1_opaque <= i_pix.opaque;
        end
    end

    // ------------------------------------------------------------------
    // Threshold decision. Since the pixel never exceeds 255, the test
    // pixel*D + entry*65280 > 255*D is the same as
    // entry*65280 > (255 - pixel)*D, which keeps both sides unsigned.
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic [PIX_W-1:0]  pix_gap;
    logic [7:0]        n_out_value;

    always_comb begin
        pix_gap = PIX_FULL - r_s1_pixel;
        lhs     = PROD_W'(rd_entry) * PROD_W'(ENTRY_SCALE);
        rhs     = PROD_W'(pix_gap) * PROD_W'(r_cfg.divisor_q8);
        if (!r_s1_opaque) begin
            n_out_value = OUT_CLEAR;
        end else if (lhs > rhs) begin
            n_out_value = OUT_WHITE;
        end else begin
            n_out_value = OUT_BLACK;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [7:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.out_value = r_out_value;

endmodule
